### design/mtfpe_pkg.sv
// Package for the move-to-front prefix encoder: sizes, the cell and rank control
// structs, the sequencer state type and the codeword function.
// No dependencies.
package mtfpe_pkg;

    localparam int ALPHABET_SIZE = 256;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 15;
    localparam int LEN_W  = 4;

    localparam logic [SYM_W-1:0] SYM_MAX = SYM_W'(ALPHABET_SIZE - 1);

    // The rank search reduces the match vector in segments of SEG_SIZE cells.
    localparam int SEG_BITS  = 4;
    localparam int SEG_SIZE  = 1 << SEG_BITS;
    localparam int SEG_COUNT = (ALPHABET_SIZE + SEG_SIZE - 1) / SEG_SIZE;
    localparam int PAD_W     = SEG_COUNT * SEG_SIZE;

    // Codeword tier bounds.
    localparam logic [SYM_W-1:0] TIER1_LAST  = 8'd3;
    localparam logic [SYM_W-1:0] TIER2_FIRST = 8'd4;
    localparam logic [SYM_W-1:0] TIER2_LAST  = 8'd18;
    localparam logic [SYM_W-1:0] TIER3_FIRST = 8'd19;

    localparam logic [LEN_W-1:0] LEN_TIER0 = 4'd1;
    localparam logic [LEN_W-1:0] LEN_TIER1 = 4'd3;
    localparam logic [LEN_W-1:0] LEN_TIER2 = 4'd7;
    localparam logic [LEN_W-1:0] LEN_TIER3 = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SEGMENT,
        ST_RANK,
        ST_UPDATE
    } mtfpe_state_t;

    typedef struct packed {
        logic             cmp_en;
        logic             shift_en;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] rank;
    } mtfpe_cell_ctl_t;

    typedef struct packed {
        logic seg_en;
        logic rank_en;
    } mtfpe_rank_ctl_t;

    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  length;
    } mtfpe_code_t;

    function automatic mtfpe_code_t mtfpe_encode(input logic [SYM_W-1:0] r);
        mtfpe_code_t      c;
        logic [SYM_W-1:0] d;
        d = '0;
        if (r == '0) begin
            c.bits   = '0;
            c.length = LEN_TIER0;
        end
        else if (r <= TIER1_LAST) begin
            d        = r - 8'd1;
            c.bits   = {12'b0, d[1:0], 1'b1};
            c.length = LEN_TIER1;
        end
        else if (r <= TIER2_LAST) begin
            d        = r - TIER2_FIRST;
            c.bits   = {8'b0, d[3:0], 3'b111};
            c.length = LEN_TIER2;
        end
        else begin
            d        = r - TIER3_FIRST;
            c.bits   = {d, 7'h7F};
            c.length = LEN_TIER3;
        end
        return c;
    endfunction

endpackage

### design/move_to_front_prefix_encoder_unit.sv
// Move-to-front byte encoder: each input beat carries one byte, and each output
// beat carries that byte's position in the move-to-front list (rank) and its prefix
// codeword. An accepted item passes through these steps: all cells compare in
// parallel, the segment and rank levels of the registered rank encoder run, and
// the cell chain moves the byte to the front. A new byte is accepted only in the
// cycle after the previous one has left the chain, so the block cannot take a new
// byte before it is through with the last one; the move to the front waits while
// an earlier result has not yet been taken from the output register.
// Depends on mtfpe_pkg, mtfpe_cell and mtfpe_rank.
module move_to_front_prefix_encoder_unit
    import mtfpe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              data_valid,
    output logic              data_ready,
    input  logic [SYM_W-1:0]  data_byte,
    output logic              code_valid,
    input  logic              code_ready,
    output logic [CODE_W-1:0] code_bits,
    output logic [LEN_W-1:0]  code_length,
    output logic [SYM_W-1:0]  rank
);

    mtfpe_state_t      state_reg;
    mtfpe_state_t      state_next;
    logic [SYM_W-1:0]  sym_reg;
    logic              code_valid_reg;
    logic              code_valid_next;
    logic [CODE_W-1:0] code_bits_reg;
    logic [LEN_W-1:0]  code_length_reg;
    logic [SYM_W-1:0]  rank_out_reg;

    logic                     accept;
    logic                     update_go;
    mtfpe_cell_ctl_t          cell_ctl;
    mtfpe_rank_ctl_t          rank_ctl;
    logic [SYM_W-1:0]         cell_value [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] match_vec;
    logic [SYM_W-1:0]         found_rank;
    mtfpe_code_t              code;

    assign accept    = data_valid && data_ready;
    assign update_go = !code_valid_reg || code_ready;

    always_comb
    begin
        state_next       = state_reg;
        data_ready       = 1'b0;
        cell_ctl.cmp_en  = 1'b0;
        cell_ctl.shift_en = 1'b0;
        cell_ctl.sym     = sym_reg;
        cell_ctl.rank    = found_rank;
        rank_ctl.seg_en  = 1'b0;
        rank_ctl.rank_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                data_ready = 1'b1;
                if (data_valid)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cell_ctl.cmp_en = 1'b1;
                state_next      = ST_SEGMENT;
            end
            ST_SEGMENT:
            begin
                rank_ctl.seg_en = 1'b1;
                state_next      = ST_RANK;
            end
            ST_RANK:
            begin
                rank_ctl.rank_en = 1'b1;
                state_next       = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (update_go)
                begin
                    cell_ctl.shift_en = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            code_valid_reg <= code_valid_next;
        end
    end

    always_comb
    begin
        code_valid_next = code_valid_reg;
        if (cell_ctl.shift_en)
        begin
            code_valid_next = 1'b1;
        end
        else if (code_ready)
        begin
            code_valid_next = 1'b0;
        end
    end

    // Bytes outside a reduced alphabet are clamped to its last symbol.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= (data_byte > SYM_MAX) ? SYM_MAX : data_byte;
        end
    end

    assign code = mtfpe_encode(found_rank);

    always_ff @(posedge clk)
    begin
        if (cell_ctl.shift_en)
        begin
            code_bits_reg   <= code.bits;
            code_length_reg <= code.length;
            rank_out_reg    <= found_rank;
        end
    end

    for (genvar p = 0; p < ALPHABET_SIZE; p++)
    begin : g_cell
        if (p == 0)
        begin : g_head
            mtfpe_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cell_ctl),
                .cell_index  (SYM_W'(p)),
                .reset_value (SYM_W'(ALPHABET_SIZE - 1 - p)),
                .prev_value  (sym_reg),
                .value       (cell_value[p]),
                .match       (match_vec[p])
            );
        end
        else
        begin : g_body
            mtfpe_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (cell_ctl),
                .cell_index  (SYM_W'(p)),
                .reset_value (SYM_W'(ALPHABET_SIZE - 1 - p)),
                .prev_value  (cell_value[p-1]),
                .value       (cell_value[p]),
                .match       (match_vec[p])
            );
        end
    end

    mtfpe_rank u_rank (
        .clk   (clk),
        .ctl   (rank_ctl),
        .match (match_vec),
        .rank  (found_rank)
    );

    assign code_valid  = code_valid_reg;
    assign code_bits   = code_bits_reg;
    assign code_length = code_length_reg;
    assign rank        = rank_out_reg;

`ifndef SYNTHESIS
    // The list is a permutation, so exactly one cell matches the symbol.
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEGMENT) |-> $onehot(match_vec))
        else $error("cell chain match vector is not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_COMPARE))
        else $error("accepted beat did not start a search");

    a_update_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ctl.shift_en |=> (code_valid && (state_reg == ST_IDLE)))
        else $error("list update did not present a result");

    a_length_legal: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (code_length == LEN_TIER0 || code_length == LEN_TIER1 ||
                        code_length == LEN_TIER2 || code_length == LEN_TIER3))
        else $error("illegal codeword length");
`endif

endmodule

### design/mtfpe_cell.sv
// One cell of the move-to-front list: holds one list entry, compares it with the
// searched symbol and takes its left neighbor's entry on a move. Uses mtfpe_pkg.
module mtfpe_cell
    import mtfpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mtfpe_cell_ctl_t  ctl,
    input  logic [SYM_W-1:0] cell_index,
    input  logic [SYM_W-1:0] reset_value,
    input  logic [SYM_W-1:0] prev_value,
    output logic [SYM_W-1:0] value,
    output logic             match
);

    logic [SYM_W-1:0] value_reg;
    logic [SYM_W-1:0] value_next;
    logic             match_reg;

    // Every cell up to and including the old position of the symbol moves back
    // by one; the head cell's neighbor is the symbol itself.
    always_comb
    begin
        value_next = value_reg;
        if (ctl.shift_en && (cell_index <= ctl.rank))
        begin
            value_next = prev_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= reset_value;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            match_reg <= (value_reg == ctl.sym);
        end
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

### design/mtfpe_rank.sv
// Two-level registered encoder that turns the one-hot match vector of the cell
// chain into the list position. Uses mtfpe_pkg.
module mtfpe_rank
    import mtfpe_pkg::*;
(
    input  logic                     clk,
    input  mtfpe_rank_ctl_t          ctl,
    input  logic [ALPHABET_SIZE-1:0] match,
    output logic [SYM_W-1:0]         rank
);

    logic [PAD_W-1:0]    match_pad;
    logic                seg_hit_next [SEG_COUNT];
    logic [SEG_BITS-1:0] seg_idx_next [SEG_COUNT];
    logic                seg_hit_reg  [SEG_COUNT];
    logic [SEG_BITS-1:0] seg_idx_reg  [SEG_COUNT];
    logic [SYM_W-1:0]    rank_next;
    logic [SYM_W-1:0]    rank_reg;

    assign match_pad = PAD_W'(match);

    always_comb
    begin
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            seg_hit_next[s] = |match_pad[s*SEG_SIZE +: SEG_SIZE];
            seg_idx_next[s] = '0;
            for (int i = 0; i < SEG_SIZE; i++)
            begin
                if (match_pad[s*SEG_SIZE + i])
                begin
                    seg_idx_next[s] = seg_idx_next[s] | SEG_BITS'(i);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.seg_en)
        begin
            for (int s = 0; s < SEG_COUNT; s++)
            begin
                seg_hit_reg[s] <= seg_hit_next[s];
                seg_idx_reg[s] <= seg_idx_next[s];
            end
        end
    end

    // Exactly one segment hits, so the segment codes can simply be ORed.
    always_comb
    begin
        rank_next = '0;
        for (int s = 0; s < SEG_COUNT; s++)
        begin
            if (seg_hit_reg[s])
            begin
                rank_next = rank_next | {(SYM_W-SEG_BITS)'(s), seg_idx_reg[s]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rank_en)
        begin
            rank_reg <= rank_next;
        end
    end

    assign rank = rank_reg;

endmodule
